// ===== sv/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constants for the silence split detector.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 24;
    localparam int MODE_BITS   = 3;
    localparam int ADDR_BITS   = 5;
    localparam int DATA_BITS   = 32;

    localparam logic [MODE_BITS-1:0] M_OFF     = 3'd0;
    localparam logic [MODE_BITS-1:0] M_DETECT  = 3'd1;
    localparam logic [MODE_BITS-1:0] M_SEARCH  = 3'd2;
    localparam logic [MODE_BITS-1:0] M_CUT     = 3'd3;
    localparam logic [MODE_BITS-1:0] M_HEADCUT = 3'd4;
    localparam logic [MODE_BITS-1:0] M_STOP    = 3'd5;

    localparam logic [2:0] REG_START_MODE      = 3'd0;
    localparam logic [2:0] REG_STEREO          = 3'd1;
    localparam logic [2:0] REG_SOUND_LEVEL     = 3'd2;
    localparam logic [2:0] REG_SILENCE_LEVEL   = 3'd3;
    localparam logic [2:0] REG_SILENCE_RUN_LEN = 3'd4;
    localparam logic [2:0] REG_SEARCH_KEEP_LEN = 3'd5;
    localparam logic [2:0] REG_HOLDOFF_LEN     = 3'd6;

    localparam logic [SAMPLE_BITS-1:0] SOUND_LEVEL_RST = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [COUNT_BITS-1:0]  CNT_MAX         = '1;

    typedef struct packed {
        logic                          op;
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          keep;
        logic                          split_after;
        logic [MODE_BITS-1:0]          mode_now;
    } result_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]   start_mode;
        logic                   stereo;
        logic [SAMPLE_BITS-1:0] sound_level;
        logic [SAMPLE_BITS-1:0] silence_level;
        logic [COUNT_BITS-1:0]  silence_run_len;
        logic [COUNT_BITS-1:0]  search_keep_len;
        logic [COUNT_BITS-1:0]  holdoff_len;
    } cfg_t;

    typedef struct packed {
        logic sound;
        logic quiet;
    } level_t;

endpackage

// ===== sv/ssd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ssd_cfg_regs
// APB register file holding the detector configuration.
// ----------------------------------------------------------------------------
module ssd_cfg_regs
    import ssd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_mode      <= M_OFF;
            cfg_reg.stereo          <= 1'b0;
            cfg_reg.sound_level     <= SOUND_LEVEL_RST;
            cfg_reg.silence_level   <= '0;
            cfg_reg.silence_run_len <= '0;
            cfg_reg.search_keep_len <= '0;
            cfg_reg.holdoff_len     <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_START_MODE:      cfg_reg.start_mode      <= pwdata[MODE_BITS-1:0];
                REG_STEREO:          cfg_reg.stereo          <= pwdata[0];
                REG_SOUND_LEVEL:     cfg_reg.sound_level     <= pwdata[SAMPLE_BITS-1:0];
                REG_SILENCE_LEVEL:   cfg_reg.silence_level   <= pwdata[SAMPLE_BITS-1:0];
                REG_SILENCE_RUN_LEN: cfg_reg.silence_run_len <= pwdata[COUNT_BITS-1:0];
                REG_SEARCH_KEEP_LEN: cfg_reg.search_keep_len <= pwdata[COUNT_BITS-1:0];
                REG_HOLDOFF_LEN:     cfg_reg.holdoff_len     <= pwdata[COUNT_BITS-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_START_MODE:      prdata = DATA_BITS'(cfg_reg.start_mode);
            REG_STEREO:          prdata = DATA_BITS'(cfg_reg.stereo);
            REG_SOUND_LEVEL:     prdata = DATA_BITS'(cfg_reg.sound_level);
            REG_SILENCE_LEVEL:   prdata = DATA_BITS'(cfg_reg.silence_level);
            REG_SILENCE_RUN_LEN: prdata = DATA_BITS'(cfg_reg.silence_run_len);
            REG_SEARCH_KEEP_LEN: prdata = DATA_BITS'(cfg_reg.search_keep_len);
            REG_HOLDOFF_LEN:     prdata = DATA_BITS'(cfg_reg.holdoff_len);
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== sv/ssd_level_cmp.sv =====
// ----------------------------------------------------------------------------
// ssd_level_cmp
// Sample magnitudes compared against the sound and silence levels.
// ----------------------------------------------------------------------------
module ssd_level_cmp
    import ssd_pkg::*;
(
    input  cfg_t                          cfg,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    output level_t                        level
);

    logic [SAMPLE_BITS-1:0] mag_l;
    logic [SAMPLE_BITS-1:0] mag_r;

    // most negative value wraps to 2^(n-1), still fits unsigned
    assign mag_l = left_sample[SAMPLE_BITS-1]  ? (~left_sample  + 1'b1) : left_sample;
    assign mag_r = right_sample[SAMPLE_BITS-1] ? (~right_sample + 1'b1) : right_sample;

    assign level.sound = (mag_l >= cfg.sound_level)
                       || (cfg.stereo && (mag_r >= cfg.sound_level));
    assign level.quiet = (mag_l < cfg.silence_level)
                       && (!cfg.stereo || (mag_r < cfg.silence_level));

endmodule

// ===== sv/ssd_step.sv =====
// ----------------------------------------------------------------------------
// ssd_step
// Mode, quiet counter and holdoff state with the per-sample update.
// ----------------------------------------------------------------------------
module ssd_step
    import ssd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 op,
    input  cfg_t                 cfg,
    input  level_t               level,
    output logic                 keep,
    output logic                 split_after,
    output logic [MODE_BITS-1:0] mode_now
);

    logic [MODE_BITS-1:0]  mode_reg, mode_next;
    logic [COUNT_BITS-1:0] quiet_reg, quiet_next;
    logic [COUNT_BITS-1:0] hold_reg, hold_next;
    logic [MODE_BITS-1:0]  reload_mode;
    logic [COUNT_BITS-1:0] reload_hold;
    logic                  keep_v;
    logic                  split_v;
    logic [1:0]            pos_v;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

    assign reload_mode = (cfg.start_mode > M_STOP) ? M_OFF : cfg.start_mode;
    assign reload_hold = (reload_mode == M_DETECT) ? cfg.holdoff_len : '0;

    always_comb
    begin
        mode_next  = mode_reg;
        quiet_next = quiet_reg;
        hold_next  = hold_reg;
        keep_v     = 1'b1;
        split_v    = 1'b0;
        pos_v      = 2'd0;

        if (op)
        begin
            mode_next  = reload_mode;
            quiet_next = '0;
            hold_next  = reload_hold;
            keep_v     = 1'b0;
        end
        else
        begin
            if (mode_next inside {[M_SEARCH:M_STOP]})
            begin
                if (level.sound)
                begin
                    quiet_next = '0;
                end
                else
                begin
                    quiet_next = sat_inc(quiet_next);
                    pos_v      = 2'd1;
                end

                if ((mode_next == M_CUT) || (mode_next == M_HEADCUT))
                begin
                    if (!level.sound)
                    begin
                        keep_v = 1'b0;
                    end
                    else if (mode_next == M_CUT)
                    begin
                        mode_next  = M_DETECT;
                        quiet_next = '0;
                        hold_next  = cfg.holdoff_len;
                    end
                    else
                    begin
                        mode_next = M_OFF;
                    end
                end
                else if (mode_next == M_SEARCH)
                begin
                    if (level.sound)
                    begin
                        mode_next  = M_DETECT;
                        quiet_next = '0;
                        hold_next  = cfg.holdoff_len;
                    end
                    if (quiet_next >= cfg.search_keep_len)
                    begin
                        if (quiet_next > cfg.search_keep_len)
                        begin
                            keep_v = 1'b0;
                        end
                        mode_next = M_CUT;
                    end
                end
            end
            else if (mode_next > M_STOP)
            begin
                mode_next = M_OFF;
            end

            // holdoff only runs down on kept samples
            if (hold_next != '0)
            begin
                if (hold_next > COUNT_BITS'(keep_v))
                begin
                    hold_next = hold_next - COUNT_BITS'(keep_v);
                end
                else
                begin
                    pos_v     = 2'd1;
                    hold_next = '0;
                end
            end

            if ((hold_next == '0) && (mode_next == M_DETECT))
            begin
                if ((pos_v < {1'b0, keep_v}) && (quiet_next < cfg.silence_run_len))
                begin
                    quiet_next = level.quiet ? sat_inc(quiet_next) : '0;
                    pos_v      = pos_v + 2'd1;
                end
                if (quiet_next >= cfg.silence_run_len)
                begin
                    keep_v     = (pos_v != 2'd0);
                    split_v    = 1'b1;
                    mode_next  = reload_mode;
                    quiet_next = '0;
                    hold_next  = reload_hold;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_OFF;
            quiet_reg <= '0;
            hold_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            quiet_reg <= quiet_next;
            hold_reg  <= hold_next;
        end
    end

    assign keep        = keep_v;
    assign split_after = split_v;
    assign mode_now    = mode_next;

endmodule

// ===== sv/silence_split_detector.sv =====
// ----------------------------------------------------------------------------
// silence_split_detector
// Per-sample silence splitter: passes samples through with keep, split and
// mode flags, under APB configuration.
// ----------------------------------------------------------------------------
// Datapath: a sample transaction is held in the input register, and its result is
//   registered into the result register when the output can take it.
// Throughput: one transaction per cycle while the result side is not stalled, set by
//   the mode and counter update between the input register and the result register.
// Reset: asynchronous, clears mode, counters, pipeline valids and the
//   configuration registers; no clearing pass.
module silence_split_detector
    import ssd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  sample_t              sample_data,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    cfg_t                 cfg;
    level_t               level;
    logic                 in_valid_reg, in_valid_next;
    sample_t              in_data_reg;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_data_reg;
    logic                 advance;
    logic                 keep;
    logic                 split_after;
    logic [MODE_BITS-1:0] mode_now;

    ssd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssd_level_cmp u_level (
        .cfg          (cfg),
        .left_sample  (in_data_reg.left_sample),
        .right_sample (in_data_reg.right_sample),
        .level        (level)
    );

    ssd_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .op          (in_data_reg.op),
        .cfg         (cfg),
        .level       (level),
        .keep        (keep),
        .split_after (split_after),
        .mode_now    (mode_now)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (sample_valid && sample_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            in_data_reg <= sample_data;
        end
        if (advance)
        begin
            out_data_reg.left_out    <= in_data_reg.left_sample;
            out_data_reg.right_out   <= in_data_reg.right_sample;
            out_data_reg.keep        <= keep;
            out_data_reg.split_after <= split_after;
            out_data_reg.mode_now    <= mode_now;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

// ===== sv/ssd_checker.sv =====
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks on the silence split detector, bound to the top level.
// ----------------------------------------------------------------------------
module ssd_checker
    import ssd_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    sample_valid,
    input logic    sample_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result_data
);

    // stalled result transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // two-deep pipeline full under a stalled output
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready
        && $past(result_valid && !result_ready)
        && $past(sample_valid && sample_ready)
        |-> !sample_ready)
        else $error("sample accepted with pipeline full");

    // no result shown during reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result valid during reset");

    // restart leaves no pending result beyond the pipeline depth
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(sample_valid && sample_ready, 1) && !$past(sample_valid && sample_ready, 2)
        && $past(rst_n, 2) && !$past(result_valid) |-> !result_valid)
        else $error("result without a sample transaction");

endmodule

bind silence_split_detector ssd_checker u_ssd_checker (.*);

// ===== tb/ssd_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssd_scoreboard
// Passive scoreboard for the silence split detector. Follows APB writes to
// keep its own copy of the configuration, predicts the result of every
// accepted sample transaction and compares each accepted result with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
package ssd_tb_pkg;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

endpackage

module ssd_scoreboard
    import ssd_pkg::*;
    import ssd_tb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    input  logic                 sample_ready,
    input  sample_t              sample_data,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  result_t              result_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output int                   errors,
    output int                   pending,
    output int                   checked,
    output int                   splits,
    output int                   drops,
    output logic [7:0]           modes_seen
);

    cfg_t                  cfg;
    logic [MODE_BITS-1:0]  mode_q;
    logic [COUNT_BITS-1:0] quiet_q;
    logic [COUNT_BITS-1:0] hold_q;
    result_t               expected_q[$];

    function automatic logic [SAMPLE_BITS-1:0] abs_level(input logic [SAMPLE_BITS-1:0] v);
        return v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v) : v;
    endfunction

    function automatic void inc_quiet();
        if (quiet_q != CNT_MAX)
            quiet_q = quiet_q + 1'b1;
    endfunction

    function automatic void restart_state();
        mode_q  = (cfg.start_mode > M_STOP) ? M_OFF : cfg.start_mode;
        quiet_q = '0;
        hold_q  = (mode_q == M_DETECT) ? cfg.holdoff_len : '0;
    endfunction

    function automatic result_t predict_result(input sample_t s);
        result_t               r;
        logic [SAMPLE_BITS-1:0] ml;
        logic [SAMPLE_BITS-1:0] mr;
        logic                  keep;
        logic                  snd;
        logic                  qt;
        int                    pos;
        ml   = abs_level(s.left_sample);
        mr   = abs_level(s.right_sample);
        keep = 1'b1;
        pos  = 0;
        r.left_out    = s.left_sample;
        r.right_out   = s.right_sample;
        r.split_after = 1'b0;
        if (s.op == OP_RESTART)
        begin
            restart_state();
            r.keep     = 1'b0;
            r.mode_now = mode_q;
            return r;
        end
        if (mode_q >= M_SEARCH && mode_q <= M_STOP)
        begin
            snd = (ml >= cfg.sound_level) || (cfg.stereo && mr >= cfg.sound_level);
            if (snd)
                quiet_q = '0;
            else
            begin
                inc_quiet();
                pos = 1;
            end
            if (mode_q == M_CUT || mode_q == M_HEADCUT)
            begin
                if (!snd)
                    keep = 1'b0;
                else if (mode_q == M_CUT)
                begin
                    mode_q  = M_DETECT;
                    quiet_q = '0;
                    hold_q  = cfg.holdoff_len;
                end
                else
                    mode_q = M_OFF;
            end
            else if (mode_q == M_SEARCH)
            begin
                if (snd)
                begin
                    mode_q  = M_DETECT;
                    quiet_q = '0;
                    hold_q  = cfg.holdoff_len;
                end
                if (quiet_q >= cfg.search_keep_len)
                begin
                    if (quiet_q > cfg.search_keep_len)
                        keep = 1'b0;
                    mode_q = M_CUT;
                end
            end
        end
        else if (mode_q > M_STOP)
            mode_q = M_OFF;

        // holdoff only runs down on kept samples
        if (hold_q != '0)
        begin
            if (hold_q > COUNT_BITS'(keep))
                hold_q = hold_q - COUNT_BITS'(keep);
            else
            begin
                pos    = int'(hold_q);
                hold_q = '0;
            end
        end

        if (hold_q == '0 && mode_q == M_DETECT)
        begin
            if (pos < int'(keep) && quiet_q < cfg.silence_run_len)
            begin
                qt = (ml < cfg.silence_level) && (!cfg.stereo || mr < cfg.silence_level);
                if (qt)
                    inc_quiet();
                else
                    quiet_q = '0;
                pos++;
            end
            if (quiet_q >= cfg.silence_run_len)
            begin
                keep          = (pos != 0);
                r.split_after = 1'b1;
                restart_state();
            end
        end
        r.keep     = keep;
        r.mode_now = mode_q;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] expv,
                                          input logic [31:0] actv);
        if (actv !== expv)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, expv, actv);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            cfg             = '0;
            cfg.sound_level = SOUND_LEVEL_RST;
            mode_q          = M_OFF;
            quiet_q         = '0;
            hold_q          = '0;
            expected_q.delete();
            errors          = 0;
            pending         = 0;
            checked         = 0;
            splits          = 0;
            drops           = 0;
            modes_seen      = '0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_BITS-1:2])
                    REG_START_MODE:      cfg.start_mode      = pwdata[MODE_BITS-1:0];
                    REG_STEREO:          cfg.stereo          = pwdata[0];
                    REG_SOUND_LEVEL:     cfg.sound_level     = pwdata[SAMPLE_BITS-1:0];
                    REG_SILENCE_LEVEL:   cfg.silence_level   = pwdata[SAMPLE_BITS-1:0];
                    REG_SILENCE_RUN_LEN: cfg.silence_run_len = pwdata[COUNT_BITS-1:0];
                    REG_SEARCH_KEEP_LEN: cfg.search_keep_len = pwdata[COUNT_BITS-1:0];
                    REG_HOLDOFF_LEN:     cfg.holdoff_len     = pwdata[COUNT_BITS-1:0];
                    default: ;
                endcase
            end

            // results leave only after passing the input and result registers, so pop first
            if (result_valid && result_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transaction, expected none actual %0h",
                             $time, result_data);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    compare_field("left_out", 32'(exp_r.left_out),
                                  32'(result_data.left_out));
                    compare_field("right_out", 32'(exp_r.right_out),
                                  32'(result_data.right_out));
                    compare_field("keep", 32'(exp_r.keep), 32'(result_data.keep));
                    compare_field("split_after", 32'(exp_r.split_after),
                                  32'(result_data.split_after));
                    compare_field("mode_now", 32'(exp_r.mode_now),
                                  32'(result_data.mode_now));
                    checked++;
                    if (exp_r.split_after)
                        splits++;
                    if (!exp_r.keep)
                        drops++;
                    modes_seen[exp_r.mode_now] = 1'b1;
                end
            end

            if (sample_valid && sample_ready)
                expected_q.push_back(predict_result(sample_data));
            pending = expected_q.size();
        end
    end

endmodule

// ===== tb/tb_silence_split_detector.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_silence_split_detector
// Stimulus and verdict for the silence split detector. A short directed set
// covers every mode and the corner cases, then randomised phases under
// changing configuration feed quiet runs, sound bursts, restarts and noise,
// with random gaps on both channels and one long result back-pressure.
// Checking is done by ssd_scoreboard.
// ----------------------------------------------------------------------------
module tb_silence_split_detector;
    import ssd_pkg::*;
    import ssd_tb_pkg::*;

    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_ITEMS      = 220;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT      = 4000;
    localparam int IDLE_PCT         = 18;
    localparam int FULL_SCALE       = 1 << (SAMPLE_BITS - 1);
    localparam int MAX_QUIET_RUN    = 40;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_ready;
    sample_t              sample_data  = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result_data;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [ADDR_BITS-1:0] paddr        = '0;
    logic [DATA_BITS-1:0] pwdata       = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    int         errors;
    int         pending;
    int         checked;
    int         splits;
    int         drops;
    logic [7:0] modes_seen;

    int   send_idle_pct = IDLE_PCT;
    int   stall_pct     = IDLE_PCT;
    logic long_hold     = 1'b0;
    int   stuck_cycles  = 0;
    cfg_t cur_cfg;

    silence_split_detector u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    ssd_scoreboard u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .errors       (errors),
        .pending      (pending),
        .checked      (checked),
        .splits       (splits),
        .drops        (drops),
        .modes_seen   (modes_seen)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                result_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready)
            || (psel && penable))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, STUCK_LIMIT, pending);
            $display("TB_ERROR");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    task automatic send_item(input logic op, input logic [SAMPLE_BITS-1:0] l,
                             input logic [SAMPLE_BITS-1:0] r);
        sample_t s;
        s.op           = op;
        s.left_sample  = l;
        s.right_sample = r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= s;
        @(posedge clk);
        while (!sample_ready) @(posedge clk);
    endtask

    task automatic settle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    task automatic set_config(input cfg_t c);
        cur_cfg = c;
        write_reg(REG_START_MODE, DATA_BITS'(c.start_mode));
        write_reg(REG_STEREO, DATA_BITS'(c.stereo));
        write_reg(REG_SOUND_LEVEL, DATA_BITS'(c.sound_level));
        write_reg(REG_SILENCE_LEVEL, DATA_BITS'(c.silence_level));
        write_reg(REG_SILENCE_RUN_LEN, DATA_BITS'(c.silence_run_len));
        write_reg(REG_SEARCH_KEEP_LEN, DATA_BITS'(c.search_keep_len));
        write_reg(REG_HOLDOFF_LEN, DATA_BITS'(c.holdoff_len));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic cfg_t make_cfg(input logic [MODE_BITS-1:0] start, input logic st,
                                      input logic [SAMPLE_BITS-1:0] snd,
                                      input logic [SAMPLE_BITS-1:0] sil,
                                      input logic [COUNT_BITS-1:0] run,
                                      input logic [COUNT_BITS-1:0] keep_len,
                                      input logic [COUNT_BITS-1:0] hold);
        cfg_t c;
        c.start_mode      = start;
        c.stereo          = st;
        c.sound_level     = snd;
        c.silence_level   = sil;
        c.silence_run_len = run;
        c.search_keep_len = keep_len;
        c.holdoff_len     = hold;
        return c;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_level();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return SOUND_LEVEL_RST;
        return SAMPLE_BITS'($urandom_range(20000, 64));
    endfunction

    function automatic logic [COUNT_BITS-1:0] pick_len();
        int r;
        r = $urandom_range(11);
        if (r == 0)
            return '0;
        else if (r == 1)
            return CNT_MAX;
        return COUNT_BITS'($urandom_range(12, 1));
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        if ($urandom_range(9) == 0)
            c.start_mode = MODE_BITS'(M_STOP + 1 + $urandom_range(1));
        else
            c.start_mode = MODE_BITS'($urandom_range(M_STOP, M_OFF));
        c.stereo          = 1'($urandom_range(1));
        c.sound_level     = pick_level();
        c.silence_level   = pick_level();
        c.silence_run_len = pick_len();
        c.search_keep_len = pick_len();
        c.holdoff_len     = pick_len();
        return c;
    endfunction

    // quiet picks below both thresholds, now and then between them
    function automatic logic [SAMPLE_BITS-1:0] shaped_level(input logic loud);
        int snd;
        int sil;
        int lo;
        int hi;
        int mag;
        snd = int'(cur_cfg.sound_level);
        sil = int'(cur_cfg.silence_level);
        if (loud)
        begin
            lo = (snd > sil) ? snd : sil;
            hi = FULL_SCALE;
        end
        else if (sil < snd && $urandom_range(4) == 0)
        begin
            lo = sil;
            hi = snd - 1;
        end
        else
        begin
            lo = 0;
            hi = ((snd < sil) ? snd : sil) - 1;
            if (hi < 0)
                hi = 0;
        end
        mag = $urandom_range(hi, lo);
        return ($urandom_range(1) != 0) ? SAMPLE_BITS'(-mag) : SAMPLE_BITS'(mag);
    endfunction

    task automatic send_shaped(input logic loud);
        logic [SAMPLE_BITS-1:0] l;
        logic [SAMPLE_BITS-1:0] r;
        l = shaped_level(loud);
        r = shaped_level(loud);
        if (!cur_cfg.stereo)
            r = SAMPLE_BITS'($urandom);
        else if ($urandom_range(5) == 0)
        begin
            if ($urandom_range(1) != 0)
                l = shaped_level(!loud);
            else
                r = shaped_level(!loud);
        end
        send_item(OP_SAMPLE, l, r);
    endtask

    task automatic random_phase(input int n_items);
        int     sent;
        int     kind;
        int     len;
        int     span;
        longint want;
        want = longint'(cur_cfg.silence_run_len) + longint'(cur_cfg.search_keep_len)
               + longint'(cur_cfg.holdoff_len) + 4;
        span = (want > MAX_QUIET_RUN) ? MAX_QUIET_RUN : int'(want);
        send_item(OP_RESTART, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
        sent = 1;
        while (sent < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 5)
            begin
                send_item(OP_RESTART, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
                sent++;
            end
            else if (kind < 20)
            begin
                len = $urandom_range(4, 1);
                repeat (len)
                begin
                    send_item(OP_SAMPLE, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
                    sent++;
                end
            end
            else if (kind < 65)
            begin
                len = $urandom_range(span, 0);
                repeat (len)
                begin
                    send_shaped(1'b0);
                    sent++;
                end
            end
            else
            begin
                len = $urandom_range(6, 1);
                repeat (len)
                begin
                    send_shaped(1'b1);
                    sent++;
                end
            end
        end
    endtask

    task automatic directed_part();
        // search: quiet run kept, then cut, right channel sound, holdoff, split
        settle();
        set_config(make_cfg(M_SEARCH, 1'b1, 16'h4000, 16'h0100, 24'd3, 24'd2, 24'd2));
        send_item(OP_RESTART, 16'h7FFF, 16'h8000);
        send_item(OP_SAMPLE, 16'h0000, 16'h0000);
        send_item(OP_SAMPLE, 16'h0001, 16'hFFFF);
        send_item(OP_SAMPLE, 16'h00FF, 16'hFF01);
        send_item(OP_SAMPLE, 16'h0000, 16'h8000);
        repeat (4) send_item(OP_SAMPLE, 16'h0000, 16'h0000);
        send_item(OP_SAMPLE, 16'h8000, 16'h0000);
        send_item(OP_RESTART, 16'h8000, 16'h7FFF);

        // out-of-range start mode falls back to off
        settle();
        set_config(make_cfg(MODE_BITS'(M_STOP + 2), 1'b0, SOUND_LEVEL_RST, '0, '0, '0, '0));
        send_item(OP_RESTART, 16'h0000, 16'h0000);
        send_item(OP_SAMPLE, 16'h7FFF, 16'h8000);
        send_item(OP_SAMPLE, 16'h8000, 16'h7FFF);

        // headcut in mono: loud right is ignored, loud left ends it
        settle();
        set_config(make_cfg(M_HEADCUT, 1'b0, 16'h1000, 16'h0800, 24'd4, 24'd4, 24'd4));
        send_item(OP_RESTART, 16'h0000, 16'h0000);
        send_item(OP_SAMPLE, 16'h0010, 16'h8000);
        send_item(OP_SAMPLE, 16'h0FFF, 16'h0000);
        send_item(OP_SAMPLE, 16'hF000, 16'h0000);

        settle();
        set_config(make_cfg(M_STOP, 1'b1, 16'h1000, '0, 24'd5, 24'd5, 24'd5));
        send_item(OP_RESTART, 16'h0000, 16'h0000);
        send_item(OP_SAMPLE, 16'h0000, 16'h0000);
        send_item(OP_SAMPLE, 16'h0000, 16'h1000);

        // zero run length: split before the sample, which is dropped
        settle();
        set_config(make_cfg(M_DETECT, 1'b1, SOUND_LEVEL_RST, 16'h7FFF, '0, '0, '0));
        send_item(OP_RESTART, 16'h0000, 16'h0000);
        send_item(OP_SAMPLE, 16'h0000, 16'h0000);
        send_item(OP_SAMPLE, 16'h8000, 16'h0000);
    endtask

    initial
    begin
        cfg_t c;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_part();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            c = random_config();
            if (p == 5)
            begin
                c.sound_level     = '0;
                c.silence_level   = SOUND_LEVEL_RST;
                c.silence_run_len = '0;
                c.search_keep_len = '0;
                c.holdoff_len     = '0;
            end
            if (p == 6)
            begin
                c.sound_level     = SOUND_LEVEL_RST;
                c.silence_level   = '0;
                c.silence_run_len = CNT_MAX;
                c.search_keep_len = CNT_MAX;
                c.holdoff_len     = CNT_MAX;
            end
            c.stereo = 1'(p % 2);
            settle();
            send_idle_pct = (p == 3) ? 0 : IDLE_PCT;
            stall_pct     = (p == 3) ? 0 : IDLE_PCT;
            set_config(c);
            if (p == 1)
                long_hold = 1'b1;
            random_phase(PHASE_ITEMS);
        end
        settle();
        repeat (8) @(posedge clk);
        $display("Coverage: %0d results checked over directed cases and %0d random phases",
                 checked, RANDOM_PHASES);
        $display("Coverage: %0d splits, %0d dropped samples, result modes seen %b",
                 splits, drops, modes_seen);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
